// ----- hw/rtl/psm_pkg.sv -----
package psm_pkg;

    localparam int VOICES       = 8;
    localparam int SAMPLE_DEPTH = 8192;

    localparam int ADDR_W   = $clog2(SAMPLE_DEPTH);
    localparam int VOICE_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CNT_W    = $clog2(VOICES + 1);
    localparam int POS_W    = 14;
    localparam int GAIN_W   = 13;
    localparam int SAMPLE_W = 16;
    localparam int VOL_W    = 7;
    localparam int SUM_W    = SAMPLE_W + 1 + VOICE_W;
    localparam int RADD_W   = ((ADDR_W > POS_W) ? ADDR_W : POS_W) + 1;

    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_TRIGGER = 2'd1,
        ACT_RENDER  = 2'd2
    } action_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [12:0]        address;
        logic signed [15:0] sample_value;
        logic [13:0]        clip_length;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] mixed_sample;
        logic [3:0]         active_voices;
    } out_item_t;

endpackage

// ----- hw/rtl/polyphonic_sample_mixer.sv -----
// channel   direction  handshake                 payload
// in        input      in_valid / in_ready       in_data  (action, address, sample, length)
// out       output     out_valid / out_ready     out_data (mixed sample, active voices)
// cfg       input      cfg_we                    cfg_data (volume percent)
//
// load and trigger beats act on acceptance; a render beat sweeps all VOICES voices:
// one voice per cycle goes through the sample memory read port and the shared
// multiplier, then S_DRAIN and S_DONE drain the read/multiply/accumulate pipe and hand off
// the frame. reset clears the voice active bits, steal cursor, volume (100) and
// output valid; sample memory holds no reset. the finished frame waits in the
// output register, and a render holds in its final step only while it is still full.
module polyphonic_sample_mixer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  psm_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output psm_pkg::out_item_t  out_data,
    input  logic                cfg_we,
    input  logic [6:0]          cfg_data
);

    import psm_pkg::*;

    // vol * 4096 / 100 == (vol * 1024 * 167773) >> 22, exact for vol in 0..100
    localparam logic [17:0] GAIN_RECIP = 18'd167773;
    localparam int          GAIN_SHIFT = 22;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RENDER,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t               state_reg;
    logic [VOL_W-1:0]     volume_reg;
    logic [VOICES-1:0]    act_reg;
    logic [VOICE_W-1:0]   cursor_reg;
    logic [VOICE_W-1:0]   iss_reg;
    logic                 drain_reg;
    logic                 out_valid_reg;
    out_item_t            out_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0]     count_reg;

    logic [ADDR_W-1:0]    start_reg [VOICES];
    logic [POS_W-1:0]     len_reg   [VOICES];
    logic [POS_W-1:0]     pos_reg   [VOICES];
    logic [GAIN_W-1:0]    gain_reg  [VOICES];

    // pipe: issue -> memory read -> multiply -> accumulate
    logic                 p1_valid_reg;
    logic [GAIN_W-1:0]    p1_gain_reg;
    logic                 p2_valid_reg;
    logic signed [SAMPLE_W+GAIN_W:0] prod_reg;

    logic                 accept;
    logic                 do_load;
    logic                 do_trigger;
    logic                 do_render;
    logic                 hit;
    logic                 last_frame;
    logic [POS_W:0]       pos_inc;
    logic [RADD_W-1:0]    raddr_sum;
    logic [ADDR_W-1:0]    raddr;
    logic [SAMPLE_W-1:0]  rdata;
    logic                 found;
    logic [VOICE_W-1:0]   free_slot;
    logic [VOICE_W-1:0]   slot;
    logic [VOL_W-1:0]     vol_cap;
    logic [34:0]          gain_prod;
    logic [GAIN_W-1:0]    new_gain;
    logic signed [SAMPLE_W+1:0] scaled;
    logic signed [SAMPLE_W-1:0] sat_sum;
    logic                 out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign do_load   = accept && (in_data.action == ACT_LOAD);
    assign do_trigger = accept && (in_data.action == ACT_TRIGGER)
                        && (in_data.clip_length != '0);
    assign do_render = accept && (in_data.action == ACT_RENDER);

    // current voice in the render sweep
    assign pos_inc    = {1'b0, pos_reg[iss_reg]} + 1'b1;
    assign hit        = act_reg[iss_reg] && (pos_reg[iss_reg] < len_reg[iss_reg]);
    assign last_frame = pos_inc >= {1'b0, len_reg[iss_reg]};
    assign raddr_sum  = RADD_W'(start_reg[iss_reg]) + RADD_W'(pos_reg[iss_reg]);
    assign raddr      = ADDR_W'(raddr_sum);

    psm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (SAMPLE_DEPTH)
    ) u_samples (
        .clk   (clk),
        .we    (do_load),
        .waddr (ADDR_W'(in_data.address)),
        .wdata (in_data.sample_value),
        .raddr (raddr),
        .rdata (rdata)
    );

    // first idle voice
    always_comb
    begin
        found     = 1'b0;
        free_slot = '0;
        for (int i = VOICES - 1; i >= 0; i--)
        begin
            if (!act_reg[i])
            begin
                found     = 1'b1;
                free_slot = VOICE_W'(i);
            end
        end
    end

    assign slot      = found ? free_slot : cursor_reg;
    assign vol_cap   = (volume_reg > VOL_W'(100)) ? VOL_W'(100) : volume_reg;
    assign gain_prod = 35'({vol_cap, 10'b0}) * 35'(GAIN_RECIP);
    assign new_gain  = GAIN_W'(gain_prod >> GAIN_SHIFT);

    // arithmetic shift floors toward minus infinity
    assign scaled  = (SAMPLE_W + 2)'(prod_reg >>> 12);
    assign sat_sum = (sum_reg > SUM_W'(32767))  ? 16'sh7fff :
                     (sum_reg < -SUM_W'(32768)) ? 16'sh8000 :
                     SAMPLE_W'(sum_reg);
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            volume_reg    <= VOL_W'(100);
            act_reg       <= '0;
            cursor_reg    <= '0;
            iss_reg       <= '0;
            drain_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            sum_reg       <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                volume_reg <= cfg_data;
            end
            if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= p1_valid_reg;
            if (p2_valid_reg)
            begin
                sum_reg   <= sum_reg + SUM_W'(scaled);
                count_reg <= count_reg + 1'b1;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (do_trigger)
                    begin
                        act_reg[slot] <= 1'b1;
                        if (!found)
                        begin
                            cursor_reg <= (cursor_reg == VOICE_W'(VOICES - 1)) ? '0
                                                                             : cursor_reg + 1'b1;
                        end
                    end
                    if (do_render)
                    begin
                        sum_reg   <= '0;
                        count_reg <= '0;
                        iss_reg   <= '0;
                        state_reg <= S_RENDER;
                    end
                end
                S_RENDER:
                begin
                    p1_valid_reg <= hit;
                    if (act_reg[iss_reg] && (!hit || last_frame))
                    begin
                        act_reg[iss_reg] <= 1'b0;
                    end
                    if (iss_reg == VOICE_W'(VOICES - 1))
                    begin
                        drain_reg <= 1'b0;
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        iss_reg <= iss_reg + 1'b1;
                    end
                end
                S_DRAIN:
                begin
                    drain_reg <= 1'b1;
                    if (drain_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DONE) && out_free)
        begin
            out_reg.mixed_sample  <= sat_sum;
            out_reg.active_voices <= 4'(count_reg);
        end
        if (do_trigger)
        begin
            start_reg[slot] <= ADDR_W'(in_data.address);
            len_reg[slot]   <= in_data.clip_length;
            pos_reg[slot]   <= '0;
            gain_reg[slot]  <= new_gain;
        end
        if ((state_reg == S_RENDER) && hit)
        begin
            pos_reg[iss_reg] <= POS_W'(pos_inc);
        end
        p1_gain_reg <= gain_reg[iss_reg];
        prod_reg    <= $signed(rdata) * $signed({1'b0, p1_gain_reg});
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ----- hw/rtl/psm_ram.sv -----
module psm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
